@@ hdl/status_led_controller_top_assert.svh @@
// Assertion macros for the status LED controller.
`ifndef STATUS_LED_CONTROLLER_TOP_ASSERT_SVH
`define STATUS_LED_CONTROLLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SLC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define SLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLC_ASSERT_NOW(label, ante, cons, msg)
`define SLC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ hdl/slc_pkg.sv @@
// Shared types and constants for the status LED controller.
package slc_pkg;

  // Event codes carried on the opcode field
  typedef enum logic [3:0] {
    OP_TASK_TICK = 4'd0,
    OP_MS_TICK   = 4'd1,
    OP_USB       = 4'd2,
    OP_LINK_CONN = 4'd3,
    OP_LINK_RUN  = 4'd4,
    OP_TX        = 4'd5,
    OP_RX        = 4'd6,
    OP_ERROR     = 4'd7,
    OP_CLEAR     = 4'd8
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_HOLD_TICKS    = 2'd0,
    REG_BLINK_PERIOD  = 2'd1,
    REG_ERROR_TIMEOUT = 2'd2
  } reg_idx_t;

  localparam int SLC_CFG_W        = 16;
  localparam int SLC_COUNTER_BITS = 16;
  localparam int SLC_NUM_LEDS     = 5;

  // Bit positions in the LED level vector
  localparam int LED_USB  = 0;
  localparam int LED_RX   = 1;
  localparam int LED_TX   = 2;
  localparam int LED_CONN = 3;
  localparam int LED_RUN  = 4;

  // Reset values of the configuration registers
  localparam logic [SLC_CFG_W-1:0] HOLD_TICKS_RST    = 16'd10;
  localparam logic [SLC_CFG_W-1:0] BLINK_PERIOD_RST  = 16'd100;
  localparam logic [SLC_CFG_W-1:0] ERROR_TIMEOUT_RST = 16'd10000;

endpackage

@@ hdl/status_led_controller_top.sv @@
// Status LED controller: activity pulse stretching, level LEDs and error blink.
`include "status_led_controller_top_assert.svh"

// Takes one event per clock and updates five LED levels plus the error-blink
// flag in a single pass of counter and compare logic. The LED state registers
// double as the result register: a result appears the cycle after its event
// is accepted, and in_stall rises only while a result is waiting and out_stall
// holds it, so a downstream that never stalls sees one transaction per clock.
// TX/RX LEDs stay lit for hold_ticks task ticks after activity (zero keeps
// them lit); an error event blinks the USB LED every blink_period_ms ms ticks
// until error_timeout_ms ms ticks pass without another error or a clear
// arrives. Configuration writes are always accepted (cfg_ready is tied high)
// and should be made while no event is in flight.
module status_led_controller_top
  import slc_pkg::*;
#(
  parameter int COUNTER_BITS = SLC_COUNTER_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // event channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           opcode,
  input  logic                 level,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 usb_led,
  output logic                 rx_led,
  output logic                 tx_led,
  output logic                 link_conn_led,
  output logic                 link_run_led,
  output logic                 error_blinking,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [SLC_CFG_W-1:0] cfg_data
);

  localparam int CMP_W = (COUNTER_BITS > SLC_CFG_W) ? COUNTER_BITS : SLC_CFG_W;

  logic [SLC_CFG_W-1:0]    hold_ticks;
  logic [SLC_CFG_W-1:0]    blink_period_ms;
  logic [SLC_CFG_W-1:0]    error_timeout_ms;

  logic [SLC_CFG_W-1:0]    tx_hold, tx_hold_next;
  logic [SLC_CFG_W-1:0]    rx_hold, rx_hold_next;
  logic [COUNTER_BITS-1:0] since_error_ms, since_error_ms_next;
  logic [COUNTER_BITS-1:0] since_toggle_ms, since_toggle_ms_next;
  logic                    blink_active, blink_active_next;
  logic                    blink_phase, blink_phase_next;
  logic [SLC_NUM_LEDS-1:0] led_levels, led_levels_next;

  logic in_accept;
  logic error_expired;
  logic toggle_due;

  // Handshake: hold off input only while a result is pending and stalled
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks       <= HOLD_TICKS_RST;
      blink_period_ms  <= BLINK_PERIOD_RST;
      error_timeout_ms <= ERROR_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_HOLD_TICKS:    hold_ticks       <= cfg_data;
        REG_BLINK_PERIOD:  blink_period_ms  <= cfg_data;
        REG_ERROR_TIMEOUT: error_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Blink timing compares, widened to a common width
  assign error_expired = CMP_W'(since_error_ms) >= CMP_W'(error_timeout_ms);
  assign toggle_due    = CMP_W'(since_toggle_ms) >= CMP_W'(blink_period_ms);

  // Next-state logic for one event
  always_comb begin
    tx_hold_next         = tx_hold;
    rx_hold_next         = rx_hold;
    since_error_ms_next  = since_error_ms;
    since_toggle_ms_next = since_toggle_ms;
    blink_active_next    = blink_active;
    blink_phase_next     = blink_phase;
    led_levels_next      = led_levels;

    case (op_t'(opcode))
      OP_TASK_TICK: begin
        // activity holds count down, LED off on reaching zero
        if (tx_hold != '0) begin
          tx_hold_next = tx_hold - 1'b1;
          if (tx_hold == SLC_CFG_W'(1)) led_levels_next[LED_TX] = 1'b0;
        end
        if (rx_hold != '0) begin
          rx_hold_next = rx_hold - 1'b1;
          if (rx_hold == SLC_CFG_W'(1)) led_levels_next[LED_RX] = 1'b0;
        end
        if (blink_active) begin
          if (error_expired) begin
            blink_active_next        = 1'b0;
            blink_phase_next         = 1'b0;
            led_levels_next[LED_USB] = 1'b1;
          end else if (toggle_due) begin
            blink_phase_next         = !blink_phase;
            led_levels_next[LED_USB] = !blink_phase;
            since_toggle_ms_next     = '0;
          end
        end
      end
      OP_MS_TICK: begin
        // saturating elapsed-time counters
        if (!(&since_error_ms))  since_error_ms_next  = since_error_ms + 1'b1;
        if (!(&since_toggle_ms)) since_toggle_ms_next = since_toggle_ms + 1'b1;
      end
      OP_USB:       led_levels_next[LED_USB]  = level;
      OP_LINK_CONN: led_levels_next[LED_CONN] = level;
      OP_LINK_RUN:  led_levels_next[LED_RUN]  = level;
      OP_TX: begin
        led_levels_next[LED_TX] = 1'b1;
        tx_hold_next            = hold_ticks;
      end
      OP_RX: begin
        led_levels_next[LED_RX] = 1'b1;
        rx_hold_next            = hold_ticks;
      end
      OP_ERROR: begin
        since_error_ms_next = '0;
        if (!blink_active) begin
          since_toggle_ms_next     = '0;
          blink_active_next        = 1'b1;
          blink_phase_next         = 1'b0;
          led_levels_next[LED_USB] = 1'b0;
        end
      end
      OP_CLEAR: begin
        if (blink_active) begin
          blink_active_next        = 1'b0;
          blink_phase_next         = 1'b0;
          led_levels_next[LED_USB] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State registers, updated once per accepted event
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_hold         <= '0;
      rx_hold         <= '0;
      since_error_ms  <= '0;
      since_toggle_ms <= '0;
      blink_active    <= 1'b0;
      blink_phase     <= 1'b0;
      led_levels      <= '0;
    end else if (in_accept) begin
      tx_hold         <= tx_hold_next;
      rx_hold         <= rx_hold_next;
      since_error_ms  <= since_error_ms_next;
      since_toggle_ms <= since_toggle_ms_next;
      blink_active    <= blink_active_next;
      blink_phase     <= blink_phase_next;
      led_levels      <= led_levels_next;
    end
  end

  // Result valid: set by an accepted event, cleared when the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result fields come straight from the state registers
  assign usb_led        = led_levels[LED_USB];
  assign rx_led         = led_levels[LED_RX];
  assign tx_led         = led_levels[LED_TX];
  assign link_conn_led  = led_levels[LED_CONN];
  assign link_run_led   = led_levels[LED_RUN];
  assign error_blinking = blink_active;

  // Checks
  `SLC_ASSERT_NOW(a_stall_only_pending, in_stall, out_valid, "stall without pending result")
  `SLC_ASSERT_NOW(a_phase_idle, !blink_active, !blink_phase, "blink phase set while idle")
  `SLC_ASSERT_NOW(a_tx_hold_lit, tx_hold != '0, led_levels[LED_TX], "TX hold running, LED off")
  `SLC_ASSERT_NEXT(a_error_blinks, in_accept && (opcode == OP_ERROR),
                   out_valid && blink_active, "error did not start blink")

endmodule
